// File: rtl/pssd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PWM soft-start duty controller.
// Depends on nothing; every other file of the block uses it.
package pssd_pkg;

    // Field widths of the transaction payloads and configuration registers.
    localparam int NOW_W      = 32;
    localparam int DEMAND_W   = 16;
    localparam int DUTY_W     = 8;
    localparam int FIXED_W    = 7;
    localparam int DIVISOR_W  = 8;
    localparam int RAMP_W     = 16;
    localparam int FREQ_W     = 9;
    localparam int CLK_W      = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Width of the product start target times ramp remainder.
    localparam int PART_PROD_W = DUTY_W + RAMP_W;

    // Highest valid PWM frequency in hertz.
    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(400);

    // Register values after reset.
    localparam logic                  RST_OUTPUT_ENABLE = 1'b0;
    localparam logic                  RST_SOFT_START    = 1'b0;
    localparam logic                  RST_VARIABLE_MODE = 1'b0;
    localparam logic [DIVISOR_W-1:0]  RST_DIVISOR       = DIVISOR_W'(100);
    localparam logic [FIXED_W-1:0]    RST_FIXED_DUTY    = FIXED_W'(50);
    localparam logic [RAMP_W-1:0]     RST_RAMP_TIME     = RAMP_W'(1000);
    localparam logic [FREQ_W-1:0]     RST_FREQUENCY     = FREQ_W'(100);
    localparam logic [CLK_W-1:0]      RST_TIMER_CLOCK   = CLK_W'(1000000);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_ENABLE,
        CFG_SOFT_START,
        CFG_VARIABLE_MODE,
        CFG_DEMAND_DIVISOR,
        CFG_FIXED_DUTY,
        CFG_RAMP_TIME,
        CFG_PWM_FREQUENCY,
        CFG_TIMER_CLOCK
    } t_cfg_idx;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_TGT_WAIT,
        S_EDGE,
        S_RAMP,
        S_RAMP1_WAIT,
        S_RAMP2_WAIT,
        S_PER,
        S_PER_WAIT,
        S_OUT
    } t_state;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/pssd_in_if.sv
`timescale 1ns / 1ps
// Input channel of the PWM soft-start duty controller: one update tick per transaction.
// Depends on pssd_pkg for the field widths.
interface pssd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             channel_on;
    logic [pssd_pkg::NOW_W-1:0]       now_ticks;
    logic [pssd_pkg::DEMAND_W-1:0]    demand_value;

    modport source (output valid, output channel_on, output now_ticks,
                    output demand_value, input ready);
    modport sink   (input valid, input channel_on, input now_ticks,
                    input demand_value, output ready);
endinterface

// File: rtl/pssd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the PWM soft-start duty controller: one result per tick.
// Depends on pssd_pkg for the field widths.
interface pssd_out_if;
    logic                         valid;
    logic                         ready;
    logic [pssd_pkg::DUTY_W-1:0]  duty_cycle;
    logic                         ramp_done;
    logic                         period_load;
    logic [pssd_pkg::CLK_W-1:0]   timer_period;

    modport source (output valid, output duty_cycle, output ramp_done,
                    output period_load, output timer_period, input ready);
    modport sink   (input valid, input duty_cycle, input ramp_done,
                    input period_load, input timer_period, output ready);
endinterface

// File: rtl/pssd_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on pssd_pkg for the status struct.
module pssd_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [$clog2(DW+1)-1:0]  i_steps,
    input  logic [DW-1:0]            i_dividend,
    input  logic [VW-1:0]            i_divisor,
    output pssd_pkg::t_div_stat      o_stat,
    output logic [DW-1:0]            o_quo,
    output logic [VW-1:0]            o_rem
);
    import pssd_pkg::*;

    localparam int SW = $clog2(DW+1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_div, n_div;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // Trial subtraction of the divisor from the shifted partial remainder.
    // The dividend arrives left-aligned, so its top bit feeds in first.
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    // Step sequencing: load on start, one bit per cycle while busy.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt - SW'(1);
            if (r_cnt == SW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

// File: rtl/pwm_soft_start_duty_controller.sv
`timescale 1ns / 1ps
// PWM soft-start duty controller top level: sequencer, state and output register.
// Depends on pssd_pkg, pssd_in_if, pssd_out_if and pssd_div.
//
// Usage: each transaction on i_in is one update tick carrying the channel enable
// bit, the system time and the demand value. For each tick exactly one result
// transaction leaves on o_out with the duty, the ramp-done flag, a period-load
// flag and the current timer period. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data, one per cycle; the user writes them only while no
// tick is in flight, since the block does not enforce this. All divisions
// (demand by divisor, elapsed time by ramp time, start target times remainder
// by ramp time, timer clock by frequency) run one after the other on a single
// restoring divider that produces one quotient bit a cycle. A tick therefore
// occupies the block for the shortest time with fixed duty, no ramp and an
// invalid frequency, and for the longest with variable duty, a running ramp
// and a valid frequency, when all four divisions run.
// i_in.ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver does not block the
// next tick, but the sequencer waits at its end until that register is free.
// Synchronous reset clears the sequencer, channel and output-valid state and restores the register defaults.
module pwm_soft_start_duty_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pssd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pssd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pssd_in_if.sink                         i_in,
    pssd_out_if.source                      o_out
);
    import pssd_pkg::*;

    localparam int DIV_W  = (TIME_WIDTH > CLK_W) ? TIME_WIDTH : CLK_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int PROD_W = 2 * DUTY_W;

    // Configuration registers.
    logic                  r_cfg_oe;
    logic                  r_cfg_sse;
    logic                  r_cfg_var;
    logic [DIVISOR_W-1:0]  r_cfg_divisor;
    logic [FIXED_W-1:0]    r_cfg_fixed;
    logic [RAMP_W-1:0]     r_cfg_ramp;
    logic [FREQ_W-1:0]     r_cfg_freq;
    logic [CLK_W-1:0]      r_cfg_clock;

    // Sequencer and tick state.
    t_state                r_state, n_state;
    logic                  r_ch, n_ch;
    logic [TIME_WIDTH-1:0] r_now, n_now;
    logic [DEMAND_W-1:0]   r_demand, n_demand;
    logic [DUTY_W-1:0]     r_tgt, n_tgt;
    logic [PROD_W-1:0]     r_whole_prod, n_whole_prod;
    logic                  r_load, n_load;

    logic                  r_prev_ch, n_prev_ch;
    logic                  r_cpl, n_cpl;
    logic [DUTY_W-1:0]     r_duty, n_duty;
    logic [TIME_WIDTH-1:0] r_start_time, n_start_time;
    logic [DUTY_W-1:0]     r_start_tgt, n_start_tgt;
    logic [FREQ_W-1:0]     r_prev_freq, n_prev_freq;
    logic [CLK_W-1:0]      r_period, n_period;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [DUTY_W-1:0]     r_out_duty, n_out_duty;
    logic                  r_out_done, n_out_done;
    logic                  r_out_load, n_out_load;
    logic [CLK_W-1:0]      r_out_period, n_out_period;

    // Divider connections.
    logic                  div_start;
    logic [STEP_W-1:0]     div_steps;
    logic [DIV_W-1:0]      div_dividend;
    logic [RAMP_W-1:0]     div_divisor;
    t_div_stat             div_stat;
    logic [DIV_W-1:0]      div_quo;
    logic [RAMP_W-1:0]     div_rem;

    // Helper terms.
    logic                  in_accept;
    logic                  out_free;
    logic                  tgt_divide;
    logic                  freq_valid;
    logic                  ramp_divide;
    logic                  whole_over;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [PART_PROD_W-1:0] part_prod;
    logic [PROD_W:0]       ramp_sum;
    logic [DUTY_W-1:0]     ramp_sat;
    logic                  e_pc;
    logic                  e_cpl;
    logic [DUTY_W-1:0]     e_duty;
    logic                  e_restart;

    // Clamp a ramp duty to the target; the top bit reports completion.
    function automatic logic [DUTY_W:0] f_clamp(input logic [DUTY_W-1:0] d,
                                                 input logic [DUTY_W-1:0] t);
        logic [DUTY_W:0] res;
        if (d >= t) begin
            res = {1'b1, t};
        end else begin
            res = {1'b0, d};
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_oe      <= RST_OUTPUT_ENABLE;
            r_cfg_sse     <= RST_SOFT_START;
            r_cfg_var     <= RST_VARIABLE_MODE;
            r_cfg_divisor <= RST_DIVISOR;
            r_cfg_fixed   <= RST_FIXED_DUTY;
            r_cfg_ramp    <= RST_RAMP_TIME;
            r_cfg_freq    <= RST_FREQUENCY;
            r_cfg_clock   <= RST_TIMER_CLOCK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OUTPUT_ENABLE:  r_cfg_oe      <= i_cfg_data[0];
                CFG_SOFT_START:     r_cfg_sse     <= i_cfg_data[0];
                CFG_VARIABLE_MODE:  r_cfg_var     <= i_cfg_data[0];
                CFG_DEMAND_DIVISOR: r_cfg_divisor <= i_cfg_data[DIVISOR_W-1:0];
                CFG_FIXED_DUTY:     r_cfg_fixed   <= i_cfg_data[FIXED_W-1:0];
                CFG_RAMP_TIME:      r_cfg_ramp    <= i_cfg_data[RAMP_W-1:0];
                CFG_PWM_FREQUENCY:  r_cfg_freq    <= i_cfg_data[FREQ_W-1:0];
                CFG_TIMER_CLOCK:    r_cfg_clock   <= i_cfg_data[CLK_W-1:0];
            endcase
        end
    end

    // Shared helper terms.
    always_comb begin
        in_accept   = i_in.valid && i_in.ready;
        out_free    = !r_out_valid || o_out.ready;
        tgt_divide  = r_cfg_var && (r_cfg_divisor != '0);
        freq_valid  = (r_cfg_freq != '0) && (r_cfg_freq <= FREQ_MAX);
        ramp_divide = (r_cfg_ramp != '0) && (r_start_tgt != '0);
        whole_over  = |div_quo[DIV_W-1:DUTY_W];
        elapsed     = r_now - r_start_time;
        part_prod   = PART_PROD_W'(r_start_tgt) * PART_PROD_W'(div_rem);
        ramp_sum    = (PROD_W+1)'(r_whole_prod) + (PROD_W+1)'(div_quo[DUTY_W-1:0]);
        ramp_sat    = (ramp_sum > (PROD_W+1)'({DUTY_W{1'b1}})) ?
                      {DUTY_W{1'b1}} : ramp_sum[DUTY_W-1:0];
    end

    // Enable-edge handling: disabled channel, soft start off, ramp restart.
    always_comb begin
        e_pc      = r_prev_ch;
        e_cpl     = r_cpl;
        e_duty    = r_duty;
        e_restart = 1'b0;
        if (!r_cfg_oe || !r_ch) begin
            e_pc   = r_ch;
            e_cpl  = 1'b0;
            e_duty = '0;
        end
        if (!r_cfg_sse) begin
            e_cpl  = 1'b1;
            e_duty = r_tgt;
        end
        if (r_ch != e_pc) begin
            e_cpl     = 1'b0;
            e_restart = 1'b1;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (in_accept) n_state = S_TGT;
            S_TGT:        n_state = tgt_divide ? S_TGT_WAIT : S_EDGE;
            S_TGT_WAIT:   if (div_stat.done) n_state = S_EDGE;
            S_EDGE:       n_state = e_cpl ? S_PER : S_RAMP;
            S_RAMP:       n_state = ramp_divide ? S_RAMP1_WAIT : S_PER;
            S_RAMP1_WAIT: if (div_stat.done) n_state = whole_over ? S_PER : S_RAMP2_WAIT;
            S_RAMP2_WAIT: if (div_stat.done) n_state = S_PER;
            S_PER:        n_state = freq_valid ? S_PER_WAIT : S_OUT;
            S_PER_WAIT:   if (div_stat.done) n_state = S_OUT;
            S_OUT:        if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and divider requests.
    always_comb begin
        i_in.ready   = 1'b0;
        div_start    = 1'b0;
        div_steps    = STEP_W'(DEMAND_W);
        div_dividend = DIV_W'(r_demand) << (DIV_W - DEMAND_W);
        div_divisor  = RAMP_W'(r_cfg_divisor);
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
            end
            S_TGT: begin
                div_start = tgt_divide;
            end
            S_RAMP: begin
                div_start    = ramp_divide;
                div_steps    = STEP_W'(TIME_WIDTH);
                div_dividend = DIV_W'(elapsed) << (DIV_W - TIME_WIDTH);
                div_divisor  = r_cfg_ramp;
            end
            S_RAMP1_WAIT: begin
                div_start    = div_stat.done && !whole_over;
                div_steps    = STEP_W'(PART_PROD_W);
                div_dividend = DIV_W'(part_prod) << (DIV_W - PART_PROD_W);
                div_divisor  = r_cfg_ramp;
            end
            S_PER: begin
                div_start    = freq_valid;
                div_steps    = STEP_W'(CLK_W);
                div_dividend = DIV_W'(r_cfg_clock) << (DIV_W - CLK_W);
                div_divisor  = RAMP_W'(r_cfg_freq);
            end
            S_TGT_WAIT, S_EDGE, S_RAMP2_WAIT, S_PER_WAIT, S_OUT: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath updates of the tick state and the output register.
    always_comb begin
        logic [DUTY_W:0] clamp;
        logic [CLK_W-1:0] period;
        clamp        = '0;
        period       = div_quo[CLK_W-1:0];
        n_ch         = r_ch;
        n_now        = r_now;
        n_demand     = r_demand;
        n_tgt        = r_tgt;
        n_whole_prod = r_whole_prod;
        n_load       = r_load;
        n_prev_ch    = r_prev_ch;
        n_cpl        = r_cpl;
        n_duty       = r_duty;
        n_start_time = r_start_time;
        n_start_tgt  = r_start_tgt;
        n_prev_freq  = r_prev_freq;
        n_period     = r_period;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_duty   = r_out_duty;
        n_out_done   = r_out_done;
        n_out_load   = r_out_load;
        n_out_period = r_out_period;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_ch     = i_in.channel_on;
                    n_now    = TIME_WIDTH'(i_in.now_ticks);
                    n_demand = i_in.demand_value;
                    n_load   = 1'b0;
                end
            end
            S_TGT: begin
                if (!tgt_divide) n_tgt = DUTY_W'(r_cfg_fixed);
            end
            S_TGT_WAIT: begin
                if (div_stat.done) n_tgt = div_quo[DUTY_W-1:0];
            end
            S_EDGE: begin
                n_cpl  = e_cpl;
                n_duty = e_duty;
                if (e_restart) begin
                    n_start_tgt  = r_tgt;
                    n_start_time = r_now;
                end
            end
            S_RAMP: begin
                // Zero ramp time completes at once; a zero start target ramps at 0.
                if (r_cfg_ramp == '0) begin
                    clamp  = f_clamp(r_tgt, r_tgt);
                    n_cpl  = clamp[DUTY_W];
                    n_duty = clamp[DUTY_W-1:0];
                end else if (r_start_tgt == '0) begin
                    clamp  = f_clamp('0, r_tgt);
                    n_cpl  = clamp[DUTY_W];
                    n_duty = clamp[DUTY_W-1:0];
                end
            end
            S_RAMP1_WAIT: begin
                if (div_stat.done) begin
                    if (whole_over) begin
                        clamp  = f_clamp({DUTY_W{1'b1}}, r_tgt);
                        n_cpl  = clamp[DUTY_W];
                        n_duty = clamp[DUTY_W-1:0];
                    end else begin
                        n_whole_prod = PROD_W'(div_quo[DUTY_W-1:0]) * PROD_W'(r_start_tgt);
                    end
                end
            end
            S_RAMP2_WAIT: begin
                if (div_stat.done) begin
                    clamp  = f_clamp(ramp_sat, r_tgt);
                    n_cpl  = clamp[DUTY_W];
                    n_duty = clamp[DUTY_W-1:0];
                end
            end
            S_PER_WAIT: begin
                // Reload when the setting changed or the held period is stale.
                if (div_stat.done) begin
                    if ((r_cfg_freq != r_prev_freq) || (r_period != period)) begin
                        n_period = period;
                        n_load   = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_duty   = r_duty;
                    n_out_done   = r_cpl;
                    n_out_load   = r_load;
                    n_out_period = r_period;
                    n_prev_freq  = r_cfg_freq;
                    n_prev_ch    = r_ch;
                end
            end
            S_PER: begin
                n_load = r_load;
            end
            default: begin
                n_load = r_load;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_ch    <= 1'b0;
            r_cpl        <= 1'b0;
            r_duty       <= '0;
            r_start_time <= '0;
            r_start_tgt  <= '0;
            r_prev_freq  <= '0;
            r_period     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_ch    <= n_prev_ch;
            r_cpl        <= n_cpl;
            r_duty       <= n_duty;
            r_start_time <= n_start_time;
            r_start_tgt  <= n_start_tgt;
            r_prev_freq  <= n_prev_freq;
            r_period     <= n_period;
            r_out_valid  <= n_out_valid;
        end
        r_ch         <= n_ch;
        r_now        <= n_now;
        r_demand     <= n_demand;
        r_tgt        <= n_tgt;
        r_whole_prod <= n_whole_prod;
        r_load       <= n_load;
        r_out_duty   <= n_out_duty;
        r_out_done   <= n_out_done;
        r_out_load   <= n_out_load;
        r_out_period <= n_out_period;
    end

    // Shared divider.
    pssd_div #(
        .DW (DIV_W),
        .VW (RAMP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Result channel.
    assign o_out.valid        = r_out_valid;
    assign o_out.duty_cycle   = r_out_duty;
    assign o_out.ramp_done    = r_out_done;
    assign o_out.period_load  = r_out_load;
    assign o_out.timer_period = r_out_period;

`ifndef SYNTH
    // An accepted tick always starts with the target computation.
    a_accept_to_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_TGT))
        else $error("accepted tick did not enter target step");

    // The divider is never restarted while it is still working.
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A finished division is only reported while the sequencer waits for one.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> ((r_state == S_TGT_WAIT) || (r_state == S_RAMP1_WAIT) ||
                           (r_state == S_RAMP2_WAIT) || (r_state == S_PER_WAIT)))
        else $error("divider result arrived outside a wait step");

    // A free output register takes the result on the next edge.
    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !r_out_valid) |=> o_out.valid)
        else $error("result not posted to the output register");
`endif

endmodule

// File: tb/sv/pssd_tick_checker.sv
`timescale 1ns / 1ps
// Checker for the PWM soft-start duty controller: watches the configuration port and both
// channels, predicts every tick result and compares it field by field with the block.
// Depends on pssd_pkg, pssd_in_if and pssd_out_if.
module pssd_tick_checker
    import pssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pssd_in_if                    in_mon,
    pssd_out_if                   out_mon,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    // One expected result of a tick.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              done;
        logic              load;
        logic [CLK_W-1:0]  period;
    } t_tick_result;

    // Shadow copy of the configuration registers.
    logic                 out_en;
    logic                 soft_start;
    logic                 var_mode;
    logic [DIVISOR_W-1:0] divisor;
    logic [FIXED_W-1:0]   fixed_duty;
    logic [RAMP_W-1:0]    ramp_time;
    logic [FREQ_W-1:0]    freq;
    logic [CLK_W-1:0]     timer_clk;

    // Shadow copy of the channel state.
    logic                 prev_ch;
    logic                 ramp_done_q;
    logic [DUTY_W-1:0]    duty_q;
    logic [NOW_W-1:0]     start_time;
    logic [DUTY_W-1:0]    start_target;
    logic [FREQ_W-1:0]    prev_freq;
    logic [CLK_W-1:0]     period_q;

    t_tick_result         tick_results_q[$];

    task automatic clear_shadow();
        out_en       = RST_OUTPUT_ENABLE;
        soft_start   = RST_SOFT_START;
        var_mode     = RST_VARIABLE_MODE;
        divisor      = RST_DIVISOR;
        fixed_duty   = RST_FIXED_DUTY;
        ramp_time    = RST_RAMP_TIME;
        freq         = RST_FREQUENCY;
        timer_clk    = RST_TIMER_CLOCK;
        prev_ch      = 1'b0;
        ramp_done_q  = 1'b0;
        duty_q       = '0;
        start_time   = '0;
        start_target = '0;
        prev_freq    = '0;
        period_q     = '0;
    endtask

    // Duty the channel is heading for: scaled demand or the fixed setting.
    function automatic logic [DUTY_W-1:0] target_of(logic [DEMAND_W-1:0] demand);
        if (var_mode && divisor != 0) begin
            return DUTY_W'(demand / divisor);
        end
        return {1'b0, fixed_duty};
    endfunction

    // Exact floor of start_target * elapsed / ramp_time, saturated to 255.
    function automatic logic [DUTY_W-1:0] ramp_level(logic [NOW_W-1:0] elapsed);
        longint unsigned el, rt, t0, whole, part, q;
        el = elapsed;
        rt = ramp_time;
        t0 = start_target;
        if (t0 == 0) begin
            return '0;
        end
        whole = el / rt;
        part  = el % rt;
        if (whole >= 256) begin
            return 8'd255;
        end
        q = whole * t0 + (t0 * part) / rt;
        return (q > 255) ? 8'd255 : DUTY_W'(q);
    endfunction

    // Advance the shadow state by one tick and return the result it produces.
    function automatic t_tick_result advance_tick(logic ch, logic [NOW_W-1:0] now,
                                                 logic [DEMAND_W-1:0] demand);
        t_tick_result      r;
        logic [DUTY_W-1:0] tgt;
        logic [DUTY_W-1:0] lvl;
        logic [CLK_W-1:0]  per;
        r.load = 1'b0;
        tgt = target_of(demand);
        if (!out_en || !ch) begin
            prev_ch     = ch;
            ramp_done_q = 1'b0;
            duty_q      = '0;
        end
        if (!soft_start) begin
            ramp_done_q = 1'b1;
            duty_q      = tgt;
        end
        // A rising enable edge restarts the ramp from the present target.
        if (ch != prev_ch) begin
            start_target = tgt;
            ramp_done_q  = 1'b0;
            start_time   = now;
        end
        if (!ramp_done_q) begin
            if (ramp_time == 0) begin
                lvl = tgt;
            end else begin
                lvl = ramp_level(now - start_time);
            end
            if (lvl >= tgt) begin
                lvl         = tgt;
                ramp_done_q = 1'b1;
            end
            duty_q = lvl;
        end
        // A valid frequency reloads the period when it changed or no longer matches.
        if (freq >= 1 && freq <= FREQ_MAX) begin
            per = CLK_W'(timer_clk / freq);
            if (freq != prev_freq || period_q != per) begin
                period_q = per;
                r.load   = 1'b1;
            end
        end
        prev_freq = freq;
        prev_ch   = ch;
        r.duty    = duty_q;
        r.done    = ramp_done_q;
        r.period  = period_q;
        return r;
    endfunction

    initial begin
        clear_shadow();
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Results are compared before the tick of the same edge is predicted.
    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result got;
        if (!i_rst_n) begin
            clear_shadow();
            tick_results_q.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                got = '{out_mon.duty_cycle, out_mon.ramp_done, out_mon.period_load,
                        out_mon.timer_period};
                if (tick_results_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected result duty=%0d done=%0b load=%0b period=%0d",
                                 $realtime, got.duty, got.done, got.load, got.period);
                    end
                end else begin
                    want = tick_results_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: result %0d mismatch: expected duty=%0d done=%0b %s",
                                     $realtime, o_checked, want.duty, want.done,
                                     $sformatf("load=%0b period=%0d", want.load, want.period));
                            $display("%0t:   got duty=%0d done=%0b load=%0b period=%0d",
                                     $realtime, got.duty, got.done, got.load, got.period);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OUTPUT_ENABLE:  out_en     = i_cfg_data[0];
                    CFG_SOFT_START:     soft_start = i_cfg_data[0];
                    CFG_VARIABLE_MODE:  var_mode   = i_cfg_data[0];
                    CFG_DEMAND_DIVISOR: divisor    = i_cfg_data[DIVISOR_W-1:0];
                    CFG_FIXED_DUTY:     fixed_duty = i_cfg_data[FIXED_W-1:0];
                    CFG_RAMP_TIME:      ramp_time  = i_cfg_data[RAMP_W-1:0];
                    CFG_PWM_FREQUENCY:  freq       = i_cfg_data[FREQ_W-1:0];
                    CFG_TIMER_CLOCK:    timer_clk  = i_cfg_data[CLK_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                tick_results_q.push_back(advance_tick(in_mon.channel_on, in_mon.now_ticks,
                                                      in_mon.demand_value));
            end
        end
        o_pending = tick_results_q.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the PWM soft-start duty controller testbench: clock, reset, configuration phases,
// directed and random update ticks, receiver stalls and the verdict.
// Depends on pssd_pkg, pssd_in_if, pssd_out_if, pssd_tick_checker and the block itself.
module tb;
    import pssd_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pssd_in_if  in_ch();
    pssd_out_if out_ch();

    int fail_count;
    int pending;
    int checked;
    int send_idle;
    int recv_idle;
    int ticks_sent;
    int settings_used;

    pwm_soft_start_duty_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pssd_tick_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Receiver stalls at random, at the rate of the present phase.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Write one configuration register.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one update tick, with random gaps ahead of it, and wait for its transaction.
    task automatic send_tick(input logic ch, input logic [NOW_W-1:0] now,
                             input logic [DEMAND_W-1:0] demand);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.channel_on   <= ch;
        in_ch.now_ticks    <= now;
        in_ch.demand_value <= demand;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        ticks_sent++;
    endtask

    // Let every expected result drain before the configuration changes.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        settings_used++;
    endtask

    task automatic pick_idling(input int phase);
        if (phase < 5) begin
            send_idle = 37;
            recv_idle = 61;
        end else if (phase < 10) begin
            send_idle = 61;
            recv_idle = 37;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    initial begin
        logic [NOW_W-1:0]    now;
        logic [DEMAND_W-1:0] demand;
        logic                ch;
        int                  ramp_len;
        int                  step;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.channel_on   = 1'b0;
        in_ch.now_ticks    = '0;
        in_ch.demand_value = '0;
        out_ch.ready       = 1'b0;
        ticks_sent         = 0;
        settings_used      = 0;
        pick_idling(0);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: output disabled, soft start off, fixed duty shown anyway.
        send_tick(1'b0, 32'h0000_0000, 16'h0000);
        send_tick(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        settle();

        // Soft start from the fixed duty, then a ramp across the time wrap.
        cfg_write(CFG_OUTPUT_ENABLE, 1);
        cfg_write(CFG_SOFT_START, 1);
        cfg_write(CFG_VARIABLE_MODE, 0);
        cfg_write(CFG_DEMAND_DIVISOR, 100);
        cfg_write(CFG_FIXED_DUTY, 127);
        cfg_write(CFG_RAMP_TIME, 1000);
        cfg_write(CFG_PWM_FREQUENCY, 400);
        cfg_write(CFG_TIMER_CLOCK, 100_000_000);
        send_tick(1'b0, 0, 0);
        send_tick(1'b1, 1000, 0);
        send_tick(1'b1, 1250, 0);
        send_tick(1'b1, 1999, 0);
        send_tick(1'b1, 2000, 0);
        send_tick(1'b0, 2100, 0);
        send_tick(1'b1, 32'hFFFF_FF00, 0);
        send_tick(1'b1, 32'h0000_0100, 0);
        settle();

        // Variable duty with soft start off, zero ramp time and zero frequency.
        cfg_write(CFG_VARIABLE_MODE, 1);
        cfg_write(CFG_DEMAND_DIVISOR, 1);
        cfg_write(CFG_RAMP_TIME, 0);
        cfg_write(CFG_PWM_FREQUENCY, 0);
        cfg_write(CFG_FIXED_DUTY, 0);
        cfg_write(CFG_SOFT_START, 0);
        send_tick(1'b1, 5, 16'hFFFF);
        send_tick(1'b1, 6, 16'h0000);
        send_tick(1'b0, 7, 16'h1234);
        send_tick(1'b1, 8, 16'h00FF);
        settle();

        // One-tick ramp, ramp saturation, zero timer clock and an out-of-range frequency.
        cfg_write(CFG_SOFT_START, 1);
        cfg_write(CFG_DEMAND_DIVISOR, 255);
        cfg_write(CFG_RAMP_TIME, 1);
        cfg_write(CFG_PWM_FREQUENCY, 511);
        cfg_write(CFG_TIMER_CLOCK, 0);
        send_tick(1'b0, 99, 16'hFFFF);
        send_tick(1'b1, 100, 16'hFFFF);
        send_tick(1'b1, 101, 16'hFFFF);
        send_tick(1'b0, 150, 16'hFFFF);
        send_tick(1'b1, 200, 16'hFFFF);
        send_tick(1'b1, 500, 16'd200);
        settle();

        // Out-of-range then lowest frequency, then a clock change that leaves the frequency alone.
        cfg_write(CFG_PWM_FREQUENCY, 401);
        cfg_write(CFG_TIMER_CLOCK, 1);
        send_tick(1'b1, 600, 16'd300);
        settle();
        cfg_write(CFG_PWM_FREQUENCY, 1);
        send_tick(1'b1, 601, 16'd300);
        settle();
        cfg_write(CFG_TIMER_CLOCK, 27'h7FF_FFFF);
        send_tick(1'b1, 602, 16'd300);
        send_tick(1'b1, 603, 16'd300);
        settle();

        // Random settings, each followed by mostly well-formed ramp sequences.
        ramp_len = 1;
        now      = $urandom;
        ch       = 1'b0;
        for (int phase = 0; phase < 14; phase++) begin
            pick_idling(phase);
            cfg_write(CFG_OUTPUT_ENABLE, ($urandom_range(9) != 0));
            cfg_write(CFG_SOFT_START, ($urandom_range(3) != 0));
            cfg_write(CFG_VARIABLE_MODE, $urandom_range(1));
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(5))
                    0:       cfg_write(CFG_DEMAND_DIVISOR, 0);
                    1:       cfg_write(CFG_DEMAND_DIVISOR, 255);
                    2:       cfg_write(CFG_DEMAND_DIVISOR, $urandom_range(1, 255));
                    default: cfg_write(CFG_DEMAND_DIVISOR, $urandom_range(1, 40));
                endcase
            end
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(3))
                    0:       cfg_write(CFG_FIXED_DUTY, 0);
                    1:       cfg_write(CFG_FIXED_DUTY, 127);
                    default: cfg_write(CFG_FIXED_DUTY, $urandom_range(127));
                endcase
            end
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(6))
                    0:       ramp_len = 0;
                    1:       ramp_len = 1;
                    2:       ramp_len = 65535;
                    3:       ramp_len = $urandom_range(65535);
                    default: ramp_len = $urandom_range(1, 2000);
                endcase
                cfg_write(CFG_RAMP_TIME, ramp_len);
            end
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(7))
                    0:       cfg_write(CFG_PWM_FREQUENCY, 0);
                    1:       cfg_write(CFG_PWM_FREQUENCY, 1);
                    2:       cfg_write(CFG_PWM_FREQUENCY, 400);
                    3:       cfg_write(CFG_PWM_FREQUENCY, $urandom_range(401, 511));
                    default: cfg_write(CFG_PWM_FREQUENCY, $urandom_range(1, 400));
                endcase
            end
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(6))
                    0:       cfg_write(CFG_TIMER_CLOCK, 0);
                    1:       cfg_write(CFG_TIMER_CLOCK, 100_000_000);
                    2:       cfg_write(CFG_TIMER_CLOCK, 27'h7FF_FFFF);
                    default: cfg_write(CFG_TIMER_CLOCK, $urandom_range(1, 100_000_000));
                endcase
            end

            for (int k = 0; k < 100; k++) begin
                step = ramp_len / 6 + 1;
                if ($urandom_range(99) < 8) begin
                    ch = ~ch;
                end
                case ($urandom_range(19))
                    0:       now = $urandom;
                    1:       now = now + $urandom_range(0, 4 * ramp_len + 1);
                    default: now = now + $urandom_range(0, step);
                endcase
                case ($urandom_range(7))
                    0:       demand = 16'h0000;
                    1:       demand = 16'hFFFF;
                    2, 3:    demand = $urandom_range(0, 2000);
                    default: demand = $urandom;
                endcase
                send_tick(ch, now, demand);
            end
            settle();
        end

        // Leave room for any stray result after the last expected one.
        repeat (150) @(negedge i_clk);
        $display("Sent %0d update ticks under %0d register settings; %0d results compared.",
                 ticks_sent, settings_used, checked);
        $display("Ramps, time wrap, saturation, both duty modes and all frequency cases hit.");
        if (fail_count == 0 && pending == 0) begin
            $display("pwm_soft_start_duty_controller verification clean");
        end else begin
            $display("pwm_soft_start_duty_controller verification failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still expected.", pending);
        $display("pwm_soft_start_duty_controller verification failed");
        $finish;
    end

endmodule
